[src/circular_deque_macros.svh]
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTH
`define CDQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CDQ_ASSERT(label, prop, msg) \
   `CDQ_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define CDQ_ASSERT_CLK(label, clk, rst, prop, msg)
`define CDQ_ASSERT(label, prop, msg)
`endif

`endif

[src/cdq_pkg.sv]
// Types, constants and index helpers for the circular deque.
package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_REAR   = 3'd3;
   localparam logic [2:0] KIND_LOOK       = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic [CNT_W-1:0]         count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // top -> control
   typedef struct packed {
      logic accept;
      logic clear;
   } ctl_type;

   // control -> top
   typedef struct packed {
      logic busy;
      logic res_valid;
   } sts_type;

   function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] idx,
                                                 logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= cap) ? '0 : IDX_W'(nxt);
   endfunction

   function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] idx,
                                                   logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] last;
      last = cap - CNT_W'(1);
      return (idx == '0 || CNT_W'(idx) >= cap) ? IDX_W'(last) : idx - IDX_W'(1);
   endfunction

endpackage

[src/cdq_ram.sv]
// Ring store: one write port, one read port, registered read data.
module cdq_ram #(
   parameter int  DEPTH = 16,
   parameter int  WIDTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cdq_ctrl.sv]
// Deque control: indices, occupancy, cached end words and the refill sequencer.
module cdq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  cdq_pkg::ctl_type                ctl,
   input  cdq_pkg::req_type                req,
   input  logic [cdq_pkg::CNT_W-1:0]       cap,
   input  logic [cdq_pkg::DATA_W-1:0]      rd_data,
   output cdq_pkg::sts_type                sts,
   output cdq_pkg::rsp_type                res,
   output logic                            mem_wr_en,
   output logic [cdq_pkg::IDX_W-1:0]       mem_wr_addr,
   output logic [cdq_pkg::DATA_W-1:0]      mem_wr_data,
   output logic                            mem_rd_en,
   output logic [cdq_pkg::IDX_W-1:0]       mem_rd_addr
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                     state_ff, state_in;
   logic [cdq_pkg::IDX_W-1:0]     head_ff, head_in;
   logic [cdq_pkg::IDX_W-1:0]     tail_ff, tail_in;
   logic [cdq_pkg::CNT_W-1:0]     occ_ff, occ_in;
   logic [cdq_pkg::DATA_W-1:0]    front_ff, front_in;
   logic [cdq_pkg::DATA_W-1:0]    rear_ff, rear_in;
   logic [cdq_pkg::DATA_W-1:0]    popped_ff, popped_in;
   logic                          read_front_ff, read_front_in;
   logic [1:0]                    status_v;
   logic                          need_read;
   logic                          res_valid;
   logic                          is_push, is_pop;

   assign is_push = (req.kind == cdq_pkg::KIND_PUSH_FRONT) ||
                    (req.kind == cdq_pkg::KIND_PUSH_REAR);
   assign is_pop  = (req.kind == cdq_pkg::KIND_POP_FRONT) ||
                    (req.kind == cdq_pkg::KIND_POP_REAR);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      popped_in     = popped_ff;
      read_front_in = read_front_ff;
      status_v      = cdq_pkg::STATUS_DONE;
      need_read     = 1'b0;
      res_valid     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_rd_addr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.accept) begin
               popped_in = '0;
               if (is_push) begin
                  if (occ_ff >= cap) begin
                     status_v = cdq_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     occ_in    = occ_ff + cdq_pkg::CNT_W'(1);
                     if (occ_ff == '0) begin
                        head_in     = '0;
                        tail_in     = '0;
                        mem_wr_addr = '0;
                        front_in    = req.push_value;
                        rear_in     = req.push_value;
                     end else if (req.kind == cdq_pkg::KIND_PUSH_FRONT) begin
                        head_in     = cdq_pkg::step_down(head_ff, cap);
                        mem_wr_addr = head_in;
                        front_in    = req.push_value;
                     end else begin
                        tail_in     = cdq_pkg::step_up(tail_ff, cap);
                        mem_wr_addr = tail_in;
                        rear_in     = req.push_value;
                     end
                  end
               end else if (is_pop) begin
                  if (occ_ff == '0) begin
                     status_v = cdq_pkg::STATUS_EMPTY;
                  end else begin
                     occ_in = occ_ff - cdq_pkg::CNT_W'(1);
                     if (req.kind == cdq_pkg::KIND_POP_FRONT) begin
                        popped_in = front_ff;
                        head_in   = cdq_pkg::step_up(head_ff, cap);
                        // two left: the new front is the cached rear word
                        if (occ_ff == cdq_pkg::CNT_W'(2)) begin
                           front_in = rear_ff;
                        end else if (occ_ff > cdq_pkg::CNT_W'(2)) begin
                           need_read     = 1'b1;
                           mem_rd_addr   = head_in;
                           read_front_in = 1'b1;
                        end
                     end else begin
                        popped_in = rear_ff;
                        tail_in   = cdq_pkg::step_down(tail_ff, cap);
                        if (occ_ff == cdq_pkg::CNT_W'(2)) begin
                           rear_in = front_ff;
                        end else if (occ_ff > cdq_pkg::CNT_W'(2)) begin
                           need_read     = 1'b1;
                           mem_rd_addr   = tail_in;
                           read_front_in = 1'b0;
                        end
                     end
                     if (occ_ff == cdq_pkg::CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end
                  end
               end
               if (need_read) begin
                  state_in = ST_READ;
               end else begin
                  res_valid = 1'b1;
               end
            end
         end
         ST_READ: begin
            // refill the exposed end from the store
            res_valid = 1'b1;
            state_in  = ST_IDLE;
            if (read_front_ff) begin
               front_in = rd_data;
            end else begin
               rear_in = rd_data;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ctl.clear) begin
         state_in = ST_IDLE;
         head_in  = '0;
         tail_in  = '0;
         occ_in   = '0;
      end
   end

   assign mem_rd_en   = need_read;
   assign mem_wr_data = req.push_value;

   always_comb begin
      res.status       = status_v;
      res.popped_value = popped_in;
      res.front_value  = (occ_in != '0) ? front_in : '0;
      res.rear_value   = (occ_in != '0) ? rear_in : '0;
      res.count        = occ_in;
      res.is_empty     = (occ_in == '0);
      res.is_full      = (occ_in >= cap);
   end

   assign sts.busy      = (state_ff == ST_READ);
   assign sts.res_valid = res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      popped_ff     <= popped_in;
      read_front_ff <= read_front_in;
   end

endmodule

[src/circular_deque.sv]
// Circular deque top level: capacity register, result register, ring store.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  cdq_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall  cdq_pkg::rsp_type
//   csr_     in         csr_valid / csr_ready  capacity (5 bits)
//
// A pop that leaves two or more words also reads the ring store: the
// new end word comes from the store, whose read data is registered.
// Synchronous reset: empty deque, capacity 16; store contents are not cleared.
// A result waits in the output register under rsp_stall; the next item is
// taken in the same cycle unless the held result is still stalled or a store read is under way.
// A capacity write empties the deque; csr_ready is low during a store read.
`include "circular_deque_macros.svh"

module circular_deque (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cdq_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cdq_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0]   csr_data
);

   cdq_pkg::ctl_type               ctl;
   cdq_pkg::sts_type               sts;
   cdq_pkg::rsp_type               res;
   logic [cdq_pkg::CNT_W-1:0]      cap_ff, cap_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   cdq_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                           req_accept;
   logic                           out_held;
   logic                           mem_wr_en, mem_rd_en;
   logic [cdq_pkg::IDX_W-1:0]      mem_wr_addr, mem_rd_addr;
   logic [cdq_pkg::DATA_W-1:0]     mem_wr_data, mem_rd_data;

   assign out_held   = rsp_valid_ff && rsp_stall;
   assign req_stall  = sts.busy || out_held;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !sts.busy;

   assign ctl.accept = req_accept;
   assign ctl.clear  = csr_valid && csr_ready;

   // zero capacity acts as one, anything above the store depth saturates
   always_comb begin
      cap_in = cap_ff;
      if (ctl.clear) begin
         if (csr_data == '0) begin
            cap_in = cdq_pkg::CNT_W'(1);
         end else if (int'(csr_data) > cdq_pkg::DEPTH) begin
            cap_in = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
         end else begin
            cap_in = cdq_pkg::CNT_W'(csr_data);
         end
      end
   end

   assign rsp_valid_in = sts.res_valid || out_held;
   assign rsp_data_in  = sts.res_valid ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req         (req_data),
      .cap         (cap_ff),
      .rd_data     (mem_rd_data),
      .sts         (sts),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr)
   );

   cdq_ram #(
      .DEPTH (cdq_pkg::DEPTH),
      .WIDTH (cdq_pkg::DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   `CDQ_ASSERT(a_read_one_cycle, sts.busy |=> !sts.busy, "store refill lasted more than one cycle")
   `CDQ_ASSERT(a_res_has_source, sts.res_valid |-> (req_accept || sts.busy), "result without a transfer in")
   `CDQ_ASSERT(a_res_no_overrun, sts.res_valid |-> !out_held, "result overwrote a stalled result")

endmodule
